[src/mbe_pkg.sv]
`default_nettype none
package mbe_pkg;
    localparam int FRAC_BITS = 28;
    localparam int MAX_ROW_WIDTH = 16384;
    localparam int COUNT_BITS = 20;
    localparam int IDX_BITS = 28;
    localparam int RW_BITS = 15;
    localparam int DIV_STEPS = IDX_BITS;

    typedef enum logic [2:0] {
        REG_LEFT = 3'd0, REG_LOWER = 3'd1, REG_CSTEP = 3'd2,
        REG_RSTEP = 3'd3, REG_WIDTH = 3'd4, REG_MAXIT = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {FR_IDLE, FR_DIV, FR_MUL, FR_PUSH} t_front_state;

    typedef enum logic [3:0] {
        BK_IDLE, BK_LOAD, BK_SQ, BK_CARD1, BK_CARD2, BK_CARD3, BK_CHECK, BK_ITER,
        BK_MULS, BK_DONE
    } t_back_state;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic signed [31:0]  cr;
        logic signed [31:0]  ci;
    } t_point;

    // floor(a*b / 2^FRAC_BITS). With 33-bit operands the result stays far
    // below the 2^60 magnitude cap, so no clamp is needed.
    function automatic logic signed [63:0] fmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        begin
            p = 66'(a) * 66'(b);
            fmul = 64'(p >>> FRAC_BITS);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = 32'(v);
    endfunction
endpackage
`default_nettype wire

[src/mbe_front.sv]
`default_nettype none
module mbe_front import mbe_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire logic [IDX_BITS-1:0]  i_idx,
    input  wire logic signed [31:0]   i_left,
    input  wire logic signed [31:0]   i_lower,
    input  wire logic [30:0]          i_cstep,
    input  wire logic [30:0]          i_rstep,
    input  wire logic [RW_BITS-1:0]   i_width,
    input  wire logic                 i_q_full,
    output logic                      o_idle,
    output logic                      o_push,
    output t_point                    o_point
);
    t_front_state r_st, n_st;
    logic [IDX_BITS-1:0] r_idx, r_quo;
    logic [RW_BITS:0]    r_rem, r_div;
    logic [4:0]          r_cnt;
    logic signed [31:0]  r_cr, r_ci;
    logic [RW_BITS:0]    w_rem2;
    logic [RW_BITS:0]    w_rw;

    always_comb begin
        if (i_width == '0)
            w_rw = (RW_BITS+1)'(1);
        else if ({1'b0, i_width} > (RW_BITS+1)'(MAX_ROW_WIDTH))
            w_rw = (RW_BITS+1)'(MAX_ROW_WIDTH);
        else
            w_rw = {1'b0, i_width};
    end

    // Restoring division, one quotient bit per cycle.
    assign w_rem2 = {r_rem[RW_BITS-1:0], r_quo[IDX_BITS-1]};

    always_comb begin
        n_st = r_st;
        case (r_st)
            FR_IDLE: if (i_go) n_st = FR_DIV;
            FR_DIV:  if (r_cnt == 5'(DIV_STEPS - 1)) n_st = FR_MUL;
            FR_MUL:  n_st = FR_PUSH;
            FR_PUSH: if (!i_q_full) n_st = FR_IDLE;
            default: n_st = FR_IDLE;
        endcase
    end

    always_comb begin
        o_idle = (r_st == FR_IDLE);
        o_push = (r_st == FR_PUSH) && !i_q_full;
        o_point.idx = r_idx;
        o_point.cr = r_cr;
        o_point.ci = r_ci;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FR_IDLE;
        end else begin
            r_st <= n_st;
        end
        case (r_st)
            FR_IDLE: begin
                r_idx <= i_idx;
                r_quo <= i_idx;
                r_rem <= '0;
                r_cnt <= '0;
                r_div <= w_rw;
            end
            FR_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                if (w_rem2 >= r_div) begin
                    r_rem <= w_rem2 - r_div;
                    r_quo <= {r_quo[IDX_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2;
                    r_quo <= {r_quo[IDX_BITS-2:0], 1'b0};
                end
            end
            FR_MUL: begin
                r_cr <= sat32(64'(i_left) + 64'(48'(r_rem) * 48'(i_cstep)));
                r_ci <= sat32(64'(i_lower) + 64'(60'(r_quo) * 60'(i_rstep)));
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[src/mbe_queue.sv]
`default_nettype none
module mbe_queue import mbe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_point      i_data,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_point      o_data
);
    t_point     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

[src/mbe_back.sv]
`default_nettype none
module mbe_back import mbe_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_empty,
    input  t_point                     i_point,
    input  wire logic [COUNT_BITS-1:0] i_max_iter,
    output logic                       o_pop,
    output logic                       o_idle,
    output logic                       o_valid,
    output logic [IDX_BITS-1:0]        o_tag,
    output logic [COUNT_BITS-1:0]      o_count
);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] FOUR = 64'sd4 <<< FRAC_BITS;

    t_back_state r_st, n_st;
    logic [IDX_BITS-1:0]   r_idx;
    logic signed [31:0]    r_cr, r_ci, r_x, r_y;
    logic signed [63:0]    r_x2, r_y2, r_xy, r_q, r_p, r_b;
    logic signed [57:0]    r_plo;
    logic [COUNT_BITS-1:0] r_cnt, r_lim;
    logic                  r_inside;
    logic                  w_card;
    logic signed [37:0]    w_qa, w_qb;
    logic signed [56:0]    w_phi;
    logic signed [75:0]    w_pfull;

    assign w_card = r_p <= (r_y2 >>> 2);

    // The cardioid product q*(q + xp) has operands of up to 38 bits; it is
    // split on the first operand into a low half (BK_CARD2) and a high half (BK_CARD3).
    assign w_qa = 38'(r_q);
    assign w_qb = 38'(r_q + 64'(r_cr) - (ONE >>> 2));
    assign w_phi = $signed(w_qa[37:19]) * w_qb;
    assign w_pfull = (76'(w_phi) <<< 19) + 76'(r_plo);

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE:  if (!i_q_empty) n_st = BK_LOAD;
            BK_LOAD:  n_st = BK_SQ;
            BK_SQ:    n_st = BK_CARD1;
            BK_CARD1: n_st = BK_CARD2;
            BK_CARD2: n_st = BK_CARD3;
            BK_CARD3: n_st = BK_CHECK;
            BK_CHECK: begin
                if (w_card || (r_b + r_y2 <= (ONE >>> 4)))
                    n_st = BK_DONE;
                else
                    n_st = BK_ITER;
            end
            BK_ITER: begin
                if (r_cnt < r_lim && (r_x2 + r_y2 < FOUR))
                    n_st = BK_MULS;
                else
                    n_st = BK_DONE;
            end
            BK_MULS:  n_st = BK_ITER;
            BK_DONE:  n_st = BK_IDLE;
            default:  n_st = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_st == BK_IDLE) && !i_q_empty;
        o_idle  = (r_st == BK_IDLE);
        o_valid = (r_st == BK_DONE);
        o_tag   = r_idx;
        o_count = r_inside ? r_lim : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
        end else begin
            r_st <= n_st;
        end
        case (r_st)
            BK_IDLE: begin
                r_idx <= i_point.idx;
                r_cr <= i_point.cr;
                r_ci <= i_point.ci;
                r_lim <= (i_max_iter == '0) ? COUNT_BITS'(1) : i_max_iter;
            end
            BK_LOAD: begin
                r_x <= r_cr;
                r_y <= r_ci;
                r_cnt <= COUNT_BITS'(1);
                r_inside <= 1'b0;
            end
            BK_SQ: begin
                // Cardioid uses xp = cr - 1/4; bulb uses cp = cr + 1.
                r_y2 <= fmul(33'(r_ci), 33'(r_ci));
                r_xy <= fmul(33'(r_cr) - 33'(ONE >>> 2), 33'(r_cr) - 33'(ONE >>> 2));
                r_b  <= fmul(33'(r_cr) + 33'(ONE), 33'(r_cr) + 33'(ONE));
            end
            BK_CARD1: r_q <= r_xy + r_y2;
            BK_CARD2: r_plo <= $signed({1'b0, w_qa[18:0]}) * w_qb;
            BK_CARD3: r_p <= 64'(w_pfull >>> FRAC_BITS);
            BK_CHECK: begin
                r_inside <= w_card || (r_b + r_y2 <= (ONE >>> 4));
                r_x2 <= fmul(33'(r_x), 33'(r_x));
                r_y2 <= fmul(33'(r_y), 33'(r_y));
                r_xy <= fmul(33'(r_x), 33'(r_y));
            end
            BK_ITER: begin
                if (r_cnt < r_lim && (r_x2 + r_y2 < FOUR)) begin
                    r_x <= sat32(r_x2 - r_y2 + 64'(r_cr));
                    r_y <= sat32(r_xy + r_xy + 64'(r_ci));
                    r_cnt <= r_cnt + COUNT_BITS'(1);
                end
            end
            BK_MULS: begin
                r_x2 <= fmul(33'(r_x), 33'(r_x));
                r_y2 <= fmul(33'(r_y), 33'(r_y));
                r_xy <= fmul(33'(r_x), 33'(r_y));
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[src/mandelbrot_escape_time_pixel.sv]
// Mandelbrot escape-time pixel engine.
// Command channel: drive i_pixel_index with start high; it is taken at a clock
// edge where busy is low. Each pixel gives one result, shown for exactly one
// cycle with o_result_valid; the receiver cannot stall it.
// Configuration: i_cfg_valid/o_cfg_ready carry i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Write only while the block is idle.
// The front divides the index by the row width, one quotient bit per cycle,
// then maps column and row to c in its multiply state (FR_MUL). A two
// entry queue feeds the back end, which runs the region tests through its
// load, square, cardioid and check states, and then spends each Mandelbrot
// iteration on an update state and a squaring state. A pixel may also wait in
// the queue behind earlier pixels; throughput follows the back end.
// busy is high while the front holds a pixel, so a new pixel can enter while
// the back end still iterates on earlier ones.
// Reset (synchronous, active low) restores the default view, empties the
// queue and drops any pixel in flight.
`default_nettype none
module mandelbrot_escape_time_pixel import mbe_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [IDX_BITS-1:0]   i_pixel_index,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [31:0]           i_cfg_data,
    output logic                       o_result_valid,
    output logic [IDX_BITS-1:0]        o_pixel_tag,
    output logic [COUNT_BITS-1:0]      o_escape_count,
    output logic [7:0]                 o_red_level
);
    logic signed [31:0]    r_left, r_lower;
    logic [30:0]           r_cstep, r_rstep;
    logic [RW_BITS-1:0]    r_width;
    logic [COUNT_BITS-1:0] r_maxit;
    logic   w_fidle, w_push, w_full, w_empty, w_pop, w_bidle;
    t_point w_pt, w_qout;

    assign o_cfg_ready = 1'b1;
    assign busy = !w_fidle;
    assign o_red_level = {o_escape_count[3:0], 4'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= -32'sd536870912;
            r_lower <= -32'sd536870912;
            r_cstep <= 31'd1048576;
            r_rstep <= 31'd1048576;
            r_width <= RW_BITS'(1024);
            r_maxit <= COUNT_BITS'(100000);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEFT:  r_left  <= i_cfg_data;
                REG_LOWER: r_lower <= i_cfg_data;
                REG_CSTEP: r_cstep <= i_cfg_data[30:0];
                REG_RSTEP: r_rstep <= i_cfg_data[30:0];
                REG_WIDTH: r_width <= i_cfg_data[RW_BITS-1:0];
                REG_MAXIT: r_maxit <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    mbe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(start), .i_idx(i_pixel_index),
        .i_left(r_left), .i_lower(r_lower), .i_cstep(r_cstep),
        .i_rstep(r_rstep), .i_width(r_width), .i_q_full(w_full),
        .o_idle(w_fidle), .o_push(w_push), .o_point(w_pt)
    );

    mbe_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_pt),
        .i_pop(w_pop), .o_full(w_full), .o_empty(w_empty), .o_data(w_qout)
    );

    mbe_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(w_empty),
        .i_point(w_qout), .i_max_iter(r_maxit), .o_pop(w_pop),
        .o_idle(w_bidle), .o_valid(o_result_valid), .o_tag(o_pixel_tag),
        .o_count(o_escape_count)
    );

    logic w_unused;
    assign w_unused = w_bidle;
endmodule
`default_nettype wire

[src/mbe_checker.sv]
`default_nettype none
module mbe_checker import mbe_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  o_result_valid,
    input wire logic [COUNT_BITS-1:0] o_escape_count,
    input wire logic [7:0]            o_red_level
);
    a_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_red_level == {o_escape_count[3:0], 4'd0})
        else $error("red level mismatch");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_escape_count != '0)
        else $error("zero escape count");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_result_valid)
        else $error("not idle after reset");
endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_result_valid(o_result_valid), .o_escape_count(o_escape_count),
    .o_red_level(o_red_level)
);
`default_nettype wire
